>>> src/plbu_pkg.sv
// Shared types and constants for the price-level book update block.
// No dependencies; used by plbu_cell, plbu_side and price_level_book_update.
`default_nettype none

package plbu_pkg;

  localparam int LEVELS     = 64;
  localparam int PRICE_BITS = 32;
  localparam int QTY_BITS   = 32;
  localparam int CNT_W      = $clog2(LEVELS + 1);

  // One resting level held by a cell
  typedef struct packed {
    logic                  valid;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
  } level_t;

  localparam level_t EMPTY_LEVEL = '{valid: 1'b0, price: '0, qty: '0};

  // Operation broadcast to every cell of one side
  typedef enum logic [1:0] {
    OP_NONE,
    OP_DEL,
    OP_UPD,
    OP_INS
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> src/plbu_cell.sv
// One price-level cell: holds a level, compares it against an update, and
// shifts to or from its neighbors. Depends on plbu_pkg.
`default_nettype none

module plbu_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          is_ask_i,
  input  logic                          cap_i,
  input  logic [plbu_pkg::PRICE_BITS-1:0] cmp_price_i,
  input  plbu_pkg::cell_ctrl_t          ctrl_i,
  input  plbu_pkg::level_t              left_i,
  input  logic                          left_ins_i,
  input  plbu_pkg::level_t              right_i,
  output plbu_pkg::level_t              lvl_o,
  output plbu_pkg::level_t              nxt_o,
  output logic                          match_o,
  output logic                          ins_o
);
  import plbu_pkg::*;

  logic                  valid_q;
  logic [PRICE_BITS-1:0] price_q;
  logic [QTY_BITS-1:0]   qty_q;
  logic                  match_q;
  logic                  ins_q;
  level_t                lvl_d;
  logic                  goes_first;

  assign lvl_o   = '{valid: valid_q, price: price_q, qty: qty_q};
  assign nxt_o   = lvl_d;
  assign match_o = match_q;
  assign ins_o   = ins_q;

  // new price sorts ahead of this cell's price
  assign goes_first = is_ask_i ? (cmp_price_i < price_q) : (cmp_price_i > price_q);

  // compare flags, taken when the word is accepted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      ins_q   <= 1'b0;
    end else if (cap_i) begin
      match_q <= valid_q && (price_q == cmp_price_i);
      ins_q   <= !valid_q || goes_first;
    end
  end

  // next level: keep, shift from a neighbor, take the new level, or new qty
  always_comb begin
    lvl_d = lvl_o;
    unique case (ctrl_i.op)
      OP_DEL: begin
        if (match_q || ins_q) lvl_d = right_i;
      end
      OP_UPD: begin
        if (match_q) lvl_d.qty = ctrl_i.qty;
      end
      OP_INS: begin
        if (left_ins_i) begin
          lvl_d = left_i;
        end else if (ins_q) begin
          lvl_d = '{valid: 1'b1, price: ctrl_i.price, qty: ctrl_i.qty};
        end
      end
      default: lvl_d = lvl_o;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= lvl_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q <= lvl_d.price;
    qty_q   <= lvl_d.qty;
  end

endmodule

`default_nettype wire

>>> src/plbu_side.sv
// One book side: a row of plbu_cell instances plus the level count.
// Decides the operation from the cell flags. Depends on plbu_pkg, plbu_cell.
`default_nettype none

module plbu_side (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            is_ask_i,
  input  logic                            cap_i,
  input  logic [plbu_pkg::PRICE_BITS-1:0] cmp_price_i,
  input  logic                            apply_i,
  input  logic [plbu_pkg::PRICE_BITS-1:0] price_i,
  input  logic [plbu_pkg::QTY_BITS-1:0]   qty_i,
  output logic [plbu_pkg::PRICE_BITS-1:0] top_price_o,
  output logic [plbu_pkg::CNT_W-1:0]      count_o,
  output logic                            dropped_o
);
  import plbu_pkg::*;

  level_t           lvl   [LEVELS];
  level_t           nxt   [LEVELS];
  level_t           left  [LEVELS];
  level_t           right [LEVELS];
  logic             left_ins [LEVELS];
  logic [LEVELS-1:0] match;
  logic [LEVELS-1:0] ins;
  logic             any_match;
  logic             full;
  logic             qty_zero;
  cell_ctrl_t       ctrl;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;

  assign any_match = |match;
  assign full      = lvl[LEVELS-1].valid;
  assign qty_zero  = (qty_i == '0);

  // neighbor wiring, empty level at both ends
  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      left[i]     = (i == 0) ? EMPTY_LEVEL : lvl[(i == 0) ? 0 : i - 1];
      left_ins[i] = (i == 0) ? 1'b0 : ins[(i == 0) ? 0 : i - 1];
      right[i]    = (i == LEVELS - 1) ? EMPTY_LEVEL : lvl[(i == LEVELS - 1) ? i : i + 1];
    end
  end

  // operation for this update
  always_comb begin
    ctrl.op    = OP_NONE;
    ctrl.price = price_i;
    ctrl.qty   = qty_i;
    count_d    = count_q;
    dropped_o  = 1'b0;
    if (apply_i) begin
      if (any_match) begin
        if (qty_zero) begin
          ctrl.op = OP_DEL;
          count_d = count_q - CNT_W'(1);
        end else begin
          ctrl.op = OP_UPD;
        end
      end else if (!qty_zero) begin
        if (full) begin
          dropped_o = 1'b1;
        end else begin
          ctrl.op = OP_INS;
          count_d = count_q + CNT_W'(1);
        end
      end
    end
  end

  for (genvar g = 0; g < LEVELS; g++) begin : g_cell
    plbu_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .is_ask_i    (is_ask_i),
      .cap_i       (cap_i),
      .cmp_price_i (cmp_price_i),
      .ctrl_i      (ctrl),
      .left_i      (left[g]),
      .left_ins_i  (left_ins[g]),
      .right_i     (right[g]),
      .lvl_o       (lvl[g]),
      .nxt_o       (nxt[g]),
      .match_o     (match[g]),
      .ins_o       (ins[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // book state after this update
  assign top_price_o = nxt[0].price;
  assign count_o     = count_d;

endmodule

`default_nettype wire

>>> src/price_level_book_update.sv
// Top level of the price-level book update block: two plbu_side rows and
// the top-of-book result register. Depends on plbu_pkg and plbu_side.
//
//  Channel  Handshake                 Word
//  in       in_valid_i / in_stall_o   side_i, price_i, quantity_i
//  out      out_valid_o / out_stall_i best_bid_o, best_ask_o, spread_o,
//                                     mid_doubled_o, bid_count_o,
//                                     ask_count_o, dropped_o
//
// For each word, the accept edge latches the compare flags of every cell
// on its side; the apply edge shifts that row and loads the result register.
// The apply edge waits while a previous result is stalled on the output.
// Reset empties both sides at once; no clearing pass is needed.
// in_stall_o is high only while an accepted word has not been applied.
`default_nettype none

module price_level_book_update (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        side_i,
  input  logic [31:0] price_i,
  input  logic [31:0] quantity_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] best_bid_o,
  output logic [31:0] best_ask_o,
  output logic signed [32:0] spread_o,
  output logic [32:0] mid_doubled_o,
  output logic [6:0]  bid_count_o,
  output logic [6:0]  ask_count_o,
  output logic        dropped_o
);
  import plbu_pkg::*;

  logic                  busy_q;
  logic                  side_q;
  logic [PRICE_BITS-1:0] price_q;
  logic [QTY_BITS-1:0]   qty_q;
  logic                  accept;
  logic                  apply;
  logic [PRICE_BITS-1:0] bid_top;
  logic [PRICE_BITS-1:0] ask_top;
  logic [CNT_W-1:0]      bid_cnt;
  logic [CNT_W-1:0]      ask_cnt;
  logic                  bid_drop;
  logic                  ask_drop;
  logic [31:0]           bb;
  logic [31:0]           ba;
  logic                  both;

  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign apply      = busy_q && (!out_valid_o || !out_stall_i);

  // accepted word held for the apply cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (apply) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      side_q  <= side_i;
      price_q <= PRICE_BITS'(price_i);
      qty_q   <= QTY_BITS'(quantity_i);
    end
  end

  plbu_side u_bid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .is_ask_i    (1'b0),
    .cap_i       (accept && !side_i),
    .cmp_price_i (PRICE_BITS'(price_i)),
    .apply_i     (apply && !side_q),
    .price_i     (price_q),
    .qty_i       (qty_q),
    .top_price_o (bid_top),
    .count_o     (bid_cnt),
    .dropped_o   (bid_drop)
  );

  plbu_side u_ask (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .is_ask_i    (1'b1),
    .cap_i       (accept && side_i),
    .cmp_price_i (PRICE_BITS'(price_i)),
    .apply_i     (apply && side_q),
    .price_i     (price_q),
    .qty_i       (qty_q),
    .top_price_o (ask_top),
    .count_o     (ask_cnt),
    .dropped_o   (ask_drop)
  );

  // top of book after the update
  assign bb   = (bid_cnt != '0) ? 32'(bid_top) : 32'd0;
  assign ba   = (ask_cnt != '0) ? 32'(ask_top) : 32'd0;
  assign both = (bid_cnt != '0) && (ask_cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (apply) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply) begin
      best_bid_o    <= bb;
      best_ask_o    <= ba;
      spread_o      <= both ? ($signed({1'b0, ba}) - $signed({1'b0, bb})) : 33'sd0;
      mid_doubled_o <= both ? ({1'b0, ba} + {1'b0, bb}) : 33'd0;
      bid_count_o   <= 7'(bid_cnt);
      ask_count_o   <= 7'(ask_cnt);
      dropped_o     <= bid_drop || ask_drop;
    end
  end

  // checks
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("accepted word not held for apply");

  a_result_from_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(busy_q))
    else $error("result appeared without a pending word");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bid_count_o <= 7'(LEVELS) && ask_count_o <= 7'(LEVELS)))
    else $error("level count beyond capacity");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dropped_o) |-> (bid_count_o == 7'(LEVELS) || ask_count_o == 7'(LEVELS)))
    else $error("level dropped while side not full");

endmodule

`default_nettype wire
